// ----- sv/xcr_pkg.sv -----
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types, character codes and digit helpers for the character
// reference decoder.
// ----------------------------------------------------------------------------
package xcr_pkg;

    // Default limit on characters collected after the ampersand
    localparam int DEF_MAX_REF_CHARS = 15;

    // Number of leading characters kept for name matching
    localparam int FIRST_CHARS = 4;
    localparam int FC_IDX_W    = $clog2(FIRST_CHARS);

    typedef logic [7:0] t_byte;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_BAD_HEX  = 3'd2,
        ST_BAD_DEC  = 3'd3,
        ST_ZERO     = 3'd4,
        ST_UNKNOWN  = 3'd5
    } t_status;

    // Character codes
    localparam t_byte CH_AMP   = 8'h26;  // &
    localparam t_byte CH_SEMI  = 8'h3B;  // ;
    localparam t_byte CH_HASH  = 8'h23;  // #
    localparam t_byte CH_X     = 8'h78;  // x
    localparam t_byte CH_L     = 8'h6C;
    localparam t_byte CH_T     = 8'h74;
    localparam t_byte CH_G     = 8'h67;
    localparam t_byte CH_A     = 8'h61;
    localparam t_byte CH_M     = 8'h6D;
    localparam t_byte CH_P     = 8'h70;
    localparam t_byte CH_O     = 8'h6F;
    localparam t_byte CH_S     = 8'h73;
    localparam t_byte CH_Q     = 8'h71;
    localparam t_byte CH_U     = 8'h75;
    localparam t_byte CH_LT    = 8'h3C;  // <
    localparam t_byte CH_GT    = 8'h3E;  // >
    localparam t_byte CH_APOS  = 8'h27;  // '
    localparam t_byte CH_QUOT  = 8'h22;  // "

    // Digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit dec_digit(input t_byte c);
        t_digit d;
        d.ok  = (c >= 8'h30) && (c <= 8'h39);
        d.val = c[3:0];
        return d;
    endfunction

    function automatic t_digit hex_digit(input t_byte c);
        t_digit d;
        d.ok  = 1'b0;
        d.val = c[3:0];
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d.ok = 1'b1;
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            // a..f and A..F: low nibble is 1..6
            d.ok  = 1'b1;
            d.val = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

// ----- sv/xcr_if.sv -----
// ----------------------------------------------------------------------------
// xcr_in_if / xcr_out_if
// Valid/ready channels of the character reference decoder.
// ----------------------------------------------------------------------------
interface xcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface xcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_char;
    logic [2:0] status;

    modport source (output valid, output decoded_char, output status, input ready);
    modport sink   (input valid, input decoded_char, input status, output ready);
endinterface

// ----- sv/xml_char_reference_decoder.sv -----
// ----------------------------------------------------------------------------
// xml_char_reference_decoder
// Scans a byte stream for &...; character references and emits one word
// per reference: the decoded byte or an error status.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                          | words
//  ---------+-----+----------------------------------+---------------------
//  i_in     | in  | text_byte[7:0]                   | one per text byte
//  o_out    | out | decoded_char[7:0], status[2:0]   | one per reference
//
//  One byte is taken per cycle, sustained, unless a result is held by a stalled
//  output. Each byte is held in the input register, where the decode and
//  accumulator update happen; a result word is then loaded into the output
//  register as its ';' (or overflowing byte) steps on, and is offered from there.
//  Reset is synchronous and returns the decoder to waiting for '&'. A stalled
//  output holds only the byte that would produce a new result; bytes that
//  give no result keep flowing.
//
module xml_char_reference_decoder #(
    parameter int MAX_REF_CHARS = xcr_pkg::DEF_MAX_REF_CHARS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xcr_in_if.sink        i_in,
    xcr_out_if.source     o_out
);
    import xcr_pkg::*;

    localparam int LEN_W = $clog2(MAX_REF_CHARS + 1);

    // Input register
    logic                r_in_valid;
    t_byte               r_in_byte;

    // Reference state
    logic                r_collecting, n_collecting;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [31:0]         r_acc, n_acc;
    logic                r_err, n_err;
    logic                r_err_hex, n_err_hex;
    t_byte               r_fc [FIRST_CHARS];
    logic                w_fc_wr;

    // Output register
    logic                r_out_valid;
    t_byte               r_out_char;
    t_status             r_out_status;

    // Stage control
    logic                w_has_result;
    t_byte               w_res_char;
    t_status             w_res_status;
    logic                w_adv;
    logic                w_step;
    logic                w_num_ref;
    logic                w_hex_mode;
    logic                w_skip;
    t_digit              w_hex;
    t_digit              w_dec;

    assign w_hex      = hex_digit(r_in_byte);
    assign w_dec      = dec_digit(r_in_byte);
    assign w_num_ref  = (r_len != '0) && (r_fc[0] == CH_HASH);
    assign w_hex_mode = (r_len >= LEN_W'(2)) && (r_fc[1] == CH_X);
    assign w_skip     = (r_len == LEN_W'(1)) && (r_in_byte == CH_X);

    // Handshake: stage moves unless it holds a result and output is blocked
    assign w_adv      = !w_has_result || !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    // Decode and next state for the byte in the input register
    always_comb begin
        n_collecting = r_collecting;
        n_len        = r_len;
        n_acc        = r_acc;
        n_err        = r_err;
        n_err_hex    = r_err_hex;
        w_fc_wr      = 1'b0;
        w_has_result = 1'b0;
        w_res_char   = '0;
        w_res_status = ST_OK;

        if (!r_collecting) begin
            if (r_in_byte == CH_AMP) begin
                n_collecting = 1'b1;
                n_len        = '0;
                n_acc        = '0;
                n_err        = 1'b0;
                n_err_hex    = 1'b0;
            end
        end else if (r_in_byte == CH_SEMI) begin
            w_has_result = 1'b1;
            n_collecting = 1'b0;
            if (w_num_ref) begin
                if (r_err) begin
                    w_res_status = r_err_hex ? ST_BAD_HEX : ST_BAD_DEC;
                end else if (r_acc == '0) begin
                    w_res_status = ST_ZERO;
                end else begin
                    w_res_char   = r_acc[7:0];
                end
            end else if (r_len == LEN_W'(2) && r_fc[0] == CH_L && r_fc[1] == CH_T) begin
                w_res_char = CH_LT;
            end else if (r_len == LEN_W'(2) && r_fc[0] == CH_G && r_fc[1] == CH_T) begin
                w_res_char = CH_GT;
            end else if (r_len == LEN_W'(3) && r_fc[0] == CH_A && r_fc[1] == CH_M
                         && r_fc[2] == CH_P) begin
                w_res_char = CH_AMP;
            end else if (r_len == LEN_W'(4) && r_fc[0] == CH_A && r_fc[1] == CH_P
                         && r_fc[2] == CH_O && r_fc[3] == CH_S) begin
                w_res_char = CH_APOS;
            end else if (r_len == LEN_W'(4) && r_fc[0] == CH_Q && r_fc[1] == CH_U
                         && r_fc[2] == CH_O && r_fc[3] == CH_T) begin
                w_res_char = CH_QUOT;
            end else begin
                w_res_status = ST_UNKNOWN;
            end
        end else if (r_len >= LEN_W'(MAX_REF_CHARS)) begin
            // overflow wins over any pending digit error
            w_has_result = 1'b1;
            n_collecting = 1'b0;
            w_res_status = ST_TOO_LONG;
        end else begin
            w_fc_wr = (r_len < LEN_W'(FIRST_CHARS));
            if (w_num_ref && !w_skip) begin
                if (w_hex_mode) begin
                    if (w_hex.ok) begin
                        n_acc = {r_acc[27:0], 4'b0} + {28'b0, w_hex.val};
                    end else if (!r_err) begin
                        n_err     = 1'b1;
                        n_err_hex = 1'b1;
                    end
                end else begin
                    if (w_dec.ok) begin
                        // x*10 = x*8 + x*2, wraps at 32 bits
                        n_acc = {r_acc[28:0], 3'b0} + {r_acc[30:0], 1'b0}
                              + {28'b0, w_dec.val};
                    end else if (!r_err) begin
                        n_err     = 1'b1;
                        n_err_hex = 1'b0;
                    end
                end
            end
            n_len = r_len + 1'b1;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
        end
    end

    // Reference state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_len        <= '0;
            r_acc        <= '0;
            r_err        <= 1'b0;
            r_err_hex    <= 1'b0;
        end else if (w_step) begin
            r_collecting <= n_collecting;
            r_len        <= n_len;
            r_acc        <= n_acc;
            r_err        <= n_err;
            r_err_hex    <= n_err_hex;
        end
    end

    // Leading characters, valid only up to r_len
    always_ff @(posedge i_clk) begin
        if (w_step && w_fc_wr) begin
            r_fc[r_len[FC_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_has_result) begin
            r_out_char   <= w_res_char;
            r_out_status <= w_res_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.decoded_char = r_out_char;
    assign o_out.status       = r_out_status;

`ifndef SYNTHESIS
    // error words always carry a zero character
    a_err_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_char == '0))
        else $error("error word with nonzero character");

    // collected length never passes the limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_REF_CHARS))
        else $error("reference length beyond limit");

    // no result while waiting for an ampersand
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_collecting) |-> !w_has_result)
        else $error("result produced outside a reference");

    // every result ends the reference and lands in the output register
    a_result_ends_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result) |=> (!r_collecting && r_out_valid))
        else $error("result did not close the reference");
`endif

endmodule
